@@ sv/slt_pkg.sv @@
package slt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int RANK_W = 5;
    localparam int SIDX_W = 4;
    localparam int NAMEH_W = 56;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    typedef struct packed {
        logic [NAMEH_W-1:0] name_high;
        logic [63:0]        name_low;
        logic [31:0]        stamp;
        logic [31:0]        elapsed;
        logic [31:0]        level;
        logic [31:0]        rows;
        logic [31:0]        score;
    } t_entry;

    typedef struct packed {
        t_entry             entry;
        logic               placed;
        logic [RANK_W-1:0]  rank;
    } t_result;

    typedef struct packed {
        logic               wr_en;
        logic [IDX_W-1:0]   wr_addr;
        logic [IDX_W-1:0]   rd_addr;
    } t_store_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_WRITE,
        ST_READ,
        ST_READ_WAIT,
        ST_DONE
    } t_state;

endpackage

@@ sv/slt_cmp.sv @@
module slt_cmp
    import slt_pkg::*;
(
    input  t_entry i_slot,
    input  t_entry i_cand,
    output logic   o_worse
);

    // Stored entry is strictly worse: lower score, then longer time, then later date.
    always_comb begin
        if (i_slot.score != i_cand.score) begin
            o_worse = (i_slot.score < i_cand.score);
        end else if (i_slot.elapsed != i_cand.elapsed) begin
            o_worse = (i_slot.elapsed > i_cand.elapsed);
        end else begin
            o_worse = (i_slot.stamp > i_cand.stamp);
        end
    end

endmodule

@@ sv/slt_store.sv @@
module slt_store
    import slt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_store_ctl i_ctl,
    input  t_entry     i_wr_data,
    output t_entry     o_rd_data
);

    t_entry                   r_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;
    t_entry                   r_rd_data;
    logic                     r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_ctl.rd_addr];
    end

    // Entries never written read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_valid[i_ctl.wr_addr] <= 1'b1;
            end
            r_rd_ok <= r_valid[i_ctl.rd_addr];
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule

@@ sv/slt_ctrl.sv @@
module slt_ctrl
    import slt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_mode,
    input  logic [SIDX_W-1:0] i_index,
    input  t_entry            i_cand,
    output logic              o_ready,
    output t_store_ctl        o_store_ctl,
    output t_entry            o_wr_data,
    input  t_entry            i_rd_data,
    output logic              o_res_valid,
    output t_result           o_res,
    input  logic              i_res_take
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_ptr, n_ptr;
    logic [CNT_W-1:0]  r_chk, n_chk;
    logic [CNT_W-1:0]  r_rank, n_rank;
    logic              r_dv, n_dv;
    logic [SIDX_W-1:0] r_index, n_index;
    t_entry            r_cand, n_cand;
    t_result           r_res, n_res;
    logic              w_worse;

    slt_cmp u_cmp (
        .i_slot  (i_rd_data),
        .i_cand  (r_cand),
        .o_worse (w_worse)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = (i_mode == MODE_READ) ? ST_READ : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_dv && w_worse) begin
                    n_state = ST_SHIFT;
                end else if (r_dv && (r_chk == CNT_W'(TABLE_ENTRIES - 1))) begin
                    n_state = ST_DONE;
                end
            end
            ST_SHIFT: begin
                if ((r_ptr <= r_rank) && !r_dv) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE:     n_state = ST_DONE;
            ST_READ:      n_state = ST_READ_WAIT;
            ST_READ_WAIT: n_state = ST_DONE;
            ST_DONE: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    // datapath and store control
    always_comb begin
        n_ptr               = r_ptr;
        n_chk               = r_chk;
        n_dv                = 1'b0;
        n_rank              = r_rank;
        n_index             = r_index;
        n_cand              = r_cand;
        n_res               = r_res;
        o_store_ctl         = '0;
        o_store_ctl.rd_addr = IDX_W'(r_ptr);
        o_wr_data           = r_cand;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_cand  = i_cand;
                    n_index = i_index;
                    n_ptr   = '0;
                end
            end
            ST_SCAN: begin
                // issue one read a cycle, compare the word that comes back
                if (r_ptr < CNT_W'(TABLE_ENTRIES)) begin
                    n_dv  = 1'b1;
                    n_chk = r_ptr;
                    n_ptr = r_ptr + 1'b1;
                end
                if (r_dv && w_worse) begin
                    n_rank = r_chk;
                    n_ptr  = CNT_W'(TABLE_ENTRIES - 1);
                    n_dv   = 1'b0;
                end else if (r_dv && (r_chk == CNT_W'(TABLE_ENTRIES - 1))) begin
                    n_res.rank   = RANK_W'(TABLE_ENTRIES);
                    n_res.placed = 1'b0;
                    n_res.entry  = '0;
                end
            end
            ST_SHIFT: begin
                // move entry ptr-1 down to ptr, bottom first
                if (r_ptr > r_rank) begin
                    o_store_ctl.rd_addr = IDX_W'(r_ptr - 1'b1);
                    n_dv  = 1'b1;
                    n_chk = r_ptr;
                    n_ptr = r_ptr - 1'b1;
                end
                if (r_dv) begin
                    o_store_ctl.wr_en   = 1'b1;
                    o_store_ctl.wr_addr = IDX_W'(r_chk);
                    o_wr_data           = i_rd_data;
                end
            end
            ST_WRITE: begin
                o_store_ctl.wr_en   = 1'b1;
                o_store_ctl.wr_addr = IDX_W'(r_rank);
                n_res.rank   = RANK_W'(r_rank);
                n_res.placed = 1'b1;
                n_res.entry  = '0;
            end
            ST_READ: begin
                o_store_ctl.rd_addr = IDX_W'(r_index);
            end
            ST_READ_WAIT: begin
                n_res.rank   = RANK_W'(r_index);
                n_res.placed = 1'b0;
                n_res.entry  = (32'(r_index) < TABLE_ENTRIES) ? i_rd_data : '0;
            end
            ST_DONE: begin
                n_dv = 1'b0;
            end
            default: begin
                n_dv = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ptr   <= '0;
            r_chk   <= '0;
            r_rank  <= '0;
            r_dv    <= 1'b0;
            r_index <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_chk   <= n_chk;
            r_rank  <= n_rank;
            r_dv    <= n_dv;
            r_index <= n_index;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
        r_res  <= n_res;
    end

    assign o_ready     = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_res       = r_res;

endmodule

@@ sv/sorted_top_list_insert.sv @@
// Channel   Dir  Signals                      Word
// s         in   i_s_tvalid/o_s_tready        tuser mode, tdata candidate or read index
// m         out  o_m_tvalid/i_m_tready        tdata rank, placed, entry read
//
// Insert: one entry is read per cycle to find the rank, then the entries below
// it move down one per cycle, limited by the single read port of the entry
// store. Read: the index is addressed, then the registered word is returned.
// Synchronous active-low reset clears the table to zeros at once (valid bits).
// One word in flight; a finished result waits in the output register under stall.
module sorted_top_list_insert
    import slt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // index[3:0], score[35:4], rows[67:36], level[99:68], elapsed[131:100],
    // stamp[163:132], name_low[227:164], name_high[291:228], zero pad
    input  logic [295:0] i_s_tdata,
    // mode[0]
    input  logic [0:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // rank[4:0], placed[5], out_score[37:6], out_rows[69:38], out_level[101:70],
    // out_elapsed[133:102], out_stamp[165:134], out_name_low[229:166],
    // out_name_high[293:230], zero pad
    output logic [295:0] o_m_tdata
);

    t_entry     w_cand;
    t_store_ctl w_ctl;
    t_entry     w_wr_data;
    t_entry     w_rd_data;
    logic       w_res_valid;
    t_result    w_res;
    logic       w_res_take;
    logic       r_m_valid;
    t_result    r_m_res;

    assign w_cand.score     = i_s_tdata[35:4];
    assign w_cand.rows      = i_s_tdata[67:36];
    assign w_cand.level     = i_s_tdata[99:68];
    assign w_cand.elapsed   = i_s_tdata[131:100];
    assign w_cand.stamp     = i_s_tdata[163:132];
    assign w_cand.name_low  = i_s_tdata[227:164];
    // drop name byte 15
    assign w_cand.name_high = i_s_tdata[283:228];

    slt_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data)
    );

    slt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .i_mode      (i_s_tuser[0]),
        .i_index     (i_s_tdata[3:0]),
        .i_cand      (w_cand),
        .o_ready     (o_s_tready),
        .o_store_ctl (w_ctl),
        .o_wr_data   (w_wr_data),
        .i_rd_data   (w_rd_data),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_take  (w_res_take)
    );

    assign w_res_take = w_res_valid && (!r_m_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_take) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_m_res <= w_res;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {2'b00, 8'h00, r_m_res.entry.name_high, r_m_res.entry.name_low,
                         r_m_res.entry.stamp, r_m_res.entry.elapsed, r_m_res.entry.level,
                         r_m_res.entry.rows, r_m_res.entry.score, r_m_res.placed,
                         r_m_res.rank};

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("accepted a second word while busy");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.wr_en |-> !o_s_tready)
        else $error("table written while idle");

    a_placed_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_m_res.placed) |->
            (r_m_res.rank != RANK_W'(TABLE_ENTRIES)))
        else $error("placed result with out-of-table rank");

    a_result_needs_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_take |-> !o_s_tready)
        else $error("result produced from idle");

endmodule

@@ tb/sorted_top_list_insert_tb.sv @@
`timescale 1ns / 100ps

module sorted_top_list_insert_tb;
    import slt_pkg::*;

    localparam int   LONG_HOLD   = 300;

    typedef struct {
        logic        mode;
        logic [3:0]  idx;
        logic [31:0] score;
        logic [31:0] rows;
        logic [31:0] level;
        logic [31:0] elapsed;
        logic [31:0] stamp;
        logic [63:0] name_low;
        logic [63:0] name_high;
    } t_word;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [295:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tready = 1'b0;
    logic         o_s_tready;
    logic         o_m_tvalid;
    logic [295:0] o_m_tdata;

    t_word   words_to_send[$];
    t_result pending_results[$];
    t_entry  board[TABLE_ENTRIES];
    t_word   on_wire;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      mismatches = 0;
    bit      hold_req = 1'b0;
    bit      hold_ack = 1'b0;
    int      hold_left = 0;

    sorted_top_list_insert dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Stored entry is strictly worse than the candidate.
    function automatic bit beats(t_entry cand, t_entry held);
        if (held.score != cand.score)
            return held.score < cand.score;
        if (held.elapsed != cand.elapsed)
            return held.elapsed > cand.elapsed;
        return held.stamp > cand.stamp;
    endfunction

    function automatic t_result rank_into_board(t_word w);
        t_result r;
        t_entry  cand;
        int      pos;
        r = '0;
        if (w.mode == MODE_READ) begin
            r.rank = RANK_W'(w.idx);
            if (int'(w.idx) < TABLE_ENTRIES)
                r.entry = board[IDX_W'(w.idx)];
            return r;
        end
        cand.score     = w.score;
        cand.rows      = w.rows;
        cand.level     = w.level;
        cand.elapsed   = w.elapsed;
        cand.stamp     = w.stamp;
        cand.name_low  = w.name_low;
        cand.name_high = w.name_high[NAMEH_W-1:0];
        pos = 0;
        while (pos < TABLE_ENTRIES && !beats(cand, board[IDX_W'(pos)]))
            pos++;
        if (pos < TABLE_ENTRIES) begin
            for (int k = TABLE_ENTRIES - 1; k > pos; k--)
                board[IDX_W'(k)] = board[IDX_W'(k-1)];
            board[IDX_W'(pos)] = cand;
            r.placed = 1'b1;
        end
        r.rank = pos[RANK_W-1:0];
        return r;
    endfunction

    function automatic t_word mk_word(logic mode, logic [3:0] idx, logic [31:0] score,
                                      logic [31:0] elapsed, logic [31:0] stamp,
                                      logic [63:0] name_low, logic [63:0] name_high);
        t_word w;
        w.mode      = mode;
        w.idx       = idx;
        w.score     = score;
        w.rows      = $urandom;
        w.level     = $urandom;
        w.elapsed   = elapsed;
        w.stamp     = stamp;
        w.name_low  = name_low;
        w.name_high = name_high;
        return w;
    endfunction

    task automatic report(string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(string fld, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report($sformatf("%s got %h want %h", fld, got, want));
    endtask

    // Driver: predict on acceptance, then offer the next word or idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            for (int k = 0; k < TABLE_ENTRIES; k++)
                board[IDX_W'(k)] = '0;
        end else begin
            if (s_tvalid && o_s_tready)
                pending_results.push_back(rank_into_board(on_wire));
            if (!s_tvalid || o_s_tready) begin
                if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_wire = words_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= on_wire.mode;
                    s_tdata  <= {4'b0, on_wire.name_high, on_wire.name_low, on_wire.stamp,
                                 on_wire.elapsed, on_wire.level, on_wire.rows,
                                 on_wire.score, on_wire.idx};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started by a toggle of hold_req.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            hold_left <= LONG_HOLD;
            hold_ack  <= hold_req;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n) begin
            if (o_m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    report("result word with no expectation");
                end else begin
                    want = pending_results.pop_front();
                    check_field("rank", 64'(o_m_tdata[4:0]), 64'(want.rank));
                    check_field("placed", 64'(o_m_tdata[5]), 64'(want.placed));
                    check_field("score", 64'(o_m_tdata[37:6]), 64'(want.entry.score));
                    check_field("rows", 64'(o_m_tdata[69:38]), 64'(want.entry.rows));
                    check_field("level", 64'(o_m_tdata[101:70]), 64'(want.entry.level));
                    check_field("elapsed", 64'(o_m_tdata[133:102]),
                                64'(want.entry.elapsed));
                    check_field("stamp", 64'(o_m_tdata[165:134]), 64'(want.entry.stamp));
                    check_field("name_low", o_m_tdata[229:166], want.entry.name_low);
                    check_field("name_high", o_m_tdata[293:230],
                                {8'h00, want.entry.name_high});
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic wait_drained();
        while (words_to_send.size() != 0 || s_tvalid || pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic run_phase(int n, int idle_pct, int stall_pct, bit long_hold);
        t_word  w;
        t_entry pick;
        @(negedge i_clk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        if (long_hold)
            hold_req = ~hold_req;
        for (int i = 0; i < n; i++) begin
            w = mk_word(($urandom_range(99) < 55) ? MODE_INSERT : MODE_READ,
                        4'($urandom_range(15)), $urandom, $urandom, $urandom,
                        {$urandom, $urandom}, {$urandom, $urandom});
            case ($urandom_range(3))
                1: begin
                    case ($urandom_range(3))
                        0: w.score = 32'h0;
                        1: w.score = 32'h1;
                        2: w.score = 32'hFFFF_FFFF;
                        default: w.score = 32'hFFFF_FFFE;
                    endcase
                    w.elapsed = $urandom_range(3);
                    w.stamp   = $urandom_range(3);
                end
                2: begin
                    // land on or next to a stored entry to hit the tie rules
                    pick = board[IDX_W'($urandom_range(TABLE_ENTRIES - 1))];
                    w.score   = pick.score;
                    w.elapsed = pick.elapsed;
                    w.stamp   = pick.stamp;
                    case ($urandom_range(3))
                        1: w.elapsed = w.elapsed + 32'd1;
                        2: w.stamp = w.stamp - 32'd1;
                        3: w.score = w.score + 32'd1;
                        default: ;
                    endcase
                end
                3: w.score = $urandom_range(3);
                default: ;
            endcase
            words_to_send.push_back(w);
        end
        wait_drained();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        words_to_send.push_back(mk_word(MODE_READ, 4'd0, 0, 0, 0, 0, 0));
        words_to_send.push_back(mk_word(MODE_READ, 4'd15, 0, 0, 0, 0, 0));
        // equal to the cleared entries: goes after all of them, not placed
        words_to_send.push_back(mk_word(MODE_INSERT, 4'd0, 0, 0, 0, 0, 0));
        words_to_send.push_back(mk_word(MODE_INSERT, 4'd15, 0, 0, 1, '1, '1));
        words_to_send.push_back(mk_word(MODE_INSERT, 4'd15, '1, '1, '1, '1, '1));
        words_to_send.push_back(mk_word(MODE_READ, 4'd0, 0, 0, 0, 0, 0));
        words_to_send.push_back(mk_word(MODE_INSERT, 4'd0, '1, '1, '1,
                                        64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210));
        words_to_send.push_back(mk_word(MODE_INSERT, 4'd0, '1, 32'hFFFF_FFFE, 0,
                                        64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA));
        words_to_send.push_back(mk_word(MODE_INSERT, 4'd0, '1, '1, 32'hFFFF_FFFE,
                                        64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555));
        words_to_send.push_back(mk_word(MODE_INSERT, 4'd0, 1, 0, 0, 0, 0));
        words_to_send.push_back(mk_word(MODE_READ, 4'd1, 0, 0, 0, 0, 0));
        words_to_send.push_back(mk_word(MODE_READ, 4'd4, 0, 0, 0, 0, 0));
        words_to_send.push_back(mk_word(MODE_READ, 4'd15, 0, 0, 0, 0, 0));
        // eight more entries move the lower ones down; the table stays short of full
        for (int i = 0; i < 8; i++)
            words_to_send.push_back(mk_word(MODE_INSERT, 4'd0, 2, $urandom, $urandom,
                                            {$urandom, $urandom}, {$urandom, $urandom}));
        words_to_send.push_back(mk_word(MODE_INSERT, 4'd0, 0, 0, 0, 0, 0));
        words_to_send.push_back(mk_word(MODE_READ, 4'd15, 0, 0, 0, 0, 0));
        wait_drained();

        run_phase(350, 0, 0, 1'b0);
        run_phase(40, 0, 0, 1'b1);
        run_phase(350, 68, 0, 1'b0);
        run_phase(350, 0, 68, 1'b0);
        run_phase(350, 12, 12, 1'b0);

        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("sorted_top_list_insert_tb: PASS");
        else
            $display("sorted_top_list_insert_tb: FAIL");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("sorted_top_list_insert_tb: FAIL");
        $finish;
    end

endmodule
